>>> hw/rtl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants for the hysteresis thermostat with setpoint.
// ----------------------------------------------------------------------------
package hts_pkg;

    typedef logic signed [11:0] temp_t;

    // Width of the internal setpoint and dead band arithmetic.
    localparam int CALC_W = 14;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 25;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_SETPOINT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT_STEP     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_INTERVAL_MS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_INTERVAL_MS = 3'd4;

    // Register reset values.
    localparam temp_t       RST_INITIAL_SETPOINT  = 12'sd400;
    localparam logic [8:0]  RST_SETPOINT_STEP     = 9'd80;
    localparam logic [7:0]  RST_HYSTERESIS        = 8'd8;
    localparam logic [15:0] RST_CHECK_INTERVAL_MS = 16'd5000;
    localparam logic [24:0] RST_SLEEP_INTERVAL_MS = 25'd21600000;

    // Setpoint saturation limits, the sensor range in 1/16 degree units.
    localparam logic signed [CALC_W-1:0] SP_MIN = -14'sd640;
    localparam logic signed [CALC_W-1:0] SP_MAX = 14'sd1360;

    // Check timer saturation value on a sleep pass.
    localparam logic [16:0] CHECK_TIME_MAX = 17'h1FFFF;

endpackage

>>> hw/rtl/hysteresis_thermostat_with_setpoint.sv
// ----------------------------------------------------------------------------
// hysteresis_thermostat_with_setpoint
// Bang-bang heater control with a dead band and a button-driven setpoint.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+---------------------------------------
//  in       | in_valid / in_stall       | elapsed_ms, up_level, down_level,
//           |                           | sample_valid, temperature
//  out      | out_valid / out_stall     | heater_on, display_update,
//           |                           | sleep_request, setpoint
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Every item passes through an input register, the control logic and a
// result register; the control logic between the two is combinational.
// One item is accepted per cycle while in_stall is low; the single pass of
// control logic sets that rate; each pass updates the state the next reads.
// Reset clears the timers, the stored sample, the heater and the button
// history, and loads the setpoint and registers with their defaults.
// A stall on the output holds the result register; the input register is
// held and in_stall raised only while it also holds an item.
//
module hysteresis_thermostat_with_setpoint
    import hts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [11:0]            elapsed_ms,
    input  logic                   up_level,
    input  logic                   down_level,
    input  logic                   sample_valid,
    input  logic signed [11:0]     temperature,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   heater_on,
    output logic                   display_update,
    output logic                   sleep_request,
    output logic signed [11:0]     setpoint,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    logic [8:0]  step_reg;
    logic [7:0]  hyst_reg;
    logic [15:0] check_int_reg;
    logic [24:0] sleep_int_reg;

    // Control state.
    temp_t       setpoint_reg, setpoint_next;
    temp_t       temp_reg, temp_next;
    logic        heater_reg, heater_next;
    logic        last_up_reg, last_down_reg;
    logic [24:0] awake_reg, awake_next;
    logic [16:0] check_reg, check_next;

    // Input register.
    logic        s1_valid_reg;
    logic [11:0] elapsed_reg;
    logic        up_reg;
    logic        down_reg;
    logic        sample_valid_reg;
    temp_t       temperature_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_heater_reg;
    logic        out_update_reg;
    logic        out_sleep_reg;
    temp_t       out_setpoint_reg;

    logic        advance;
    logic        item_fire;
    logic        cfg_fire;
    logic        update_next;
    logic        sleep_next;

    logic [25:0] awake_sum;
    logic [17:0] check_sum;
    logic signed [CALC_W-1:0] step_ext;
    logic signed [CALC_W-1:0] hyst_ext;
    logic signed [CALC_W-1:0] sp_cur;
    logic signed [CALC_W-1:0] sp_up_sum;
    logic signed [CALC_W-1:0] sp_after_up;
    logic signed [CALC_W-1:0] sp_down_sum;
    logic signed [CALC_W-1:0] sp_after_down;
    logic signed [CALC_W-1:0] band_low;
    logic signed [CALC_W-1:0] band_high;
    logic signed [CALC_W-1:0] temp_ext;
    logic        up_edge;
    logic        down_edge;

    // The result register frees up when it is empty or being taken; the
    // input register drains into it whenever it frees up.
    assign advance   = !out_valid_reg || !out_stall;
    assign item_fire = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign out_valid      = out_valid_reg;
    assign heater_on      = out_heater_reg;
    assign display_update = out_update_reg;
    assign sleep_request  = out_sleep_reg;
    assign setpoint       = out_setpoint_reg;

    // One control pass on the item held in the input register.
    always_comb
    begin
        awake_sum = {1'b0, awake_reg} + {14'd0, elapsed_reg};
        check_sum = {1'b0, check_reg} + {6'd0, elapsed_reg};
        step_ext  = $signed({5'd0, step_reg});
        hyst_ext  = $signed({6'd0, hyst_reg});
        sp_cur    = CALC_W'(setpoint_reg);
        up_edge   = !up_reg && last_up_reg;
        down_edge = !down_reg && last_down_reg;

        // A step never carries the setpoint past the sensor range, and a step
        // toward a limit leaves a setpoint already beyond it where it is.
        sp_up_sum   = sp_cur + step_ext;
        sp_after_up = sp_cur;
        if (up_edge)
        begin
            if (sp_up_sum > SP_MAX)
                sp_after_up = (sp_cur > SP_MAX) ? sp_cur : SP_MAX;
            else
                sp_after_up = sp_up_sum;
        end
        sp_down_sum   = sp_after_up - step_ext;
        sp_after_down = sp_after_up;
        if (down_edge)
        begin
            if (sp_down_sum < SP_MIN)
                sp_after_down = (sp_after_up < SP_MIN) ? sp_after_up : SP_MIN;
            else
                sp_after_down = sp_down_sum;
        end

        temp_next = sample_valid_reg ? temperature_reg : temp_reg;
        temp_ext  = CALC_W'(temp_next);
        band_low  = sp_after_down - hyst_ext;
        band_high = sp_after_down + hyst_ext;

        setpoint_next = setpoint_reg;
        heater_next   = heater_reg;
        awake_next    = awake_reg;
        check_next    = check_reg;
        update_next   = 1'b0;
        sleep_next    = 1'b0;

        if (awake_sum > {1'b0, sleep_int_reg})
        begin
            // Sleep pass: heater forced off, samples and buttons ignored,
            // and the check timer keeps running without a decision.
            sleep_next  = 1'b1;
            update_next = heater_reg;
            heater_next = 1'b0;
            awake_next  = '0;
            temp_next   = temp_reg;
            check_next  = check_sum[17] ? CHECK_TIME_MAX : check_sum[16:0];
        end
        else
        begin
            awake_next    = awake_sum[24:0];
            setpoint_next = sp_after_down[11:0];
            update_next   = sample_valid_reg || up_edge || down_edge;
            if (check_sum > {2'd0, check_int_reg})
            begin
                // Inside the dead band the heater keeps its state.
                if (temp_ext < band_low)
                begin
                    heater_next = 1'b1;
                    if (!heater_reg)
                        update_next = 1'b1;
                end
                else if (temp_ext > band_high)
                begin
                    heater_next = 1'b0;
                    if (heater_reg)
                        update_next = 1'b1;
                end
                check_next = '0;
            end
            else
            begin
                check_next = check_sum[16:0];
            end
        end
    end

    // Configuration registers and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= RST_SETPOINT_STEP;
            hyst_reg      <= RST_HYSTERESIS;
            check_int_reg <= RST_CHECK_INTERVAL_MS;
            sleep_int_reg <= RST_SLEEP_INTERVAL_MS;
            setpoint_reg  <= RST_INITIAL_SETPOINT;
            temp_reg      <= '0;
            heater_reg    <= 1'b0;
            last_up_reg   <= 1'b0;
            last_down_reg <= 1'b0;
            awake_reg     <= '0;
            check_reg     <= '0;
        end
        else
        begin
            if (item_fire)
            begin
                setpoint_reg <= setpoint_next;
                temp_reg     <= temp_next;
                heater_reg   <= heater_next;
                awake_reg    <= awake_next;
                check_reg    <= check_next;
                // Button history is frozen on a sleep pass.
                if (!sleep_next)
                begin
                    last_up_reg   <= up_reg;
                    last_down_reg <= down_reg;
                end
            end
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    REG_INITIAL_SETPOINT:  setpoint_reg  <= cfg_data[11:0];
                    REG_SETPOINT_STEP:     step_reg      <= cfg_data[8:0];
                    REG_HYSTERESIS:        hyst_reg      <= cfg_data[7:0];
                    REG_CHECK_INTERVAL_MS: check_int_reg <= cfg_data[15:0];
                    REG_SLEEP_INTERVAL_MS: sleep_int_reg <= cfg_data[24:0];
                    default:               ;
                endcase
            end
        end
    end

    // Valid bits of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload of the input and result registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            elapsed_reg      <= elapsed_ms;
            up_reg           <= up_level;
            down_reg         <= down_level;
            sample_valid_reg <= sample_valid;
            temperature_reg  <= temperature;
        end
        if (item_fire)
        begin
            out_heater_reg   <= heater_next;
            out_update_reg   <= update_next;
            out_sleep_reg    <= sleep_next;
            out_setpoint_reg <= setpoint_next;
        end
    end

`ifndef SYNTHESIS
    // The input side only stalls behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall raised while the result register can move");

    // A sleep pass always leaves the heater off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sleep_request) |-> !heater_on)
        else $error("heater reported on during a sleep request");

    // The heater only changes when an item is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_fire |=> $stable(heater_reg))
        else $error("heater state changed without an item");

    // A new result only appears after an item left the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(item_fire))
        else $error("result appeared without a processed item");
`endif

endmodule
